>>> rtl/core/wnt_pkg.sv
// Shared types and constants for the word/number tokenizer.
package wnt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_scan_mode;

    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic CFG_SKIP_MODE  = 1'b0;
    localparam logic CFG_WORD_LIMIT = 1'b1;

    localparam logic       SKIP_MODE_RESET  = 1'b1;
    localparam logic [7:0] WORD_LIMIT_RESET = 8'd64;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       tend;
        logic       last;
    } t_result;

    // Results of one scan step: count (0..2) and the two slots in order.
    typedef struct packed {
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

>>> rtl/core/wnt_scan.sv
// Scanner state and one-step token logic: turns a character into 0..2 results.
module wnt_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_char,
    input  logic                i_eoi,
    input  logic                i_skip_mode,
    input  logic [7:0]          i_word_limit,
    output wnt_pkg::t_step      o_step
);

    wnt_pkg::t_scan_mode r_mode, n_mode;
    logic [7:0]          r_held_char, n_held_char;
    logic                r_held_valid, n_held_valid;
    logic                r_held_num, n_held_num;
    logic [7:0]          r_token_length, n_token_length;
    logic                r_dot_seen, n_dot_seen;

    logic [7:0] limit;
    logic       cont;
    logic       flush;
    logic       is_alnum;
    logic       is_blank;
    logic       in_comment;
    logic [1:0] held_kind;

    assign limit     = (i_word_limit == 8'd0) ? 8'd1 : i_word_limit;
    assign is_alnum  = wnt_pkg::is_letter(i_char) || wnt_pkg::is_digit(i_char);
    assign is_blank  = (i_char == wnt_pkg::CH_SPACE) || (i_char == wnt_pkg::CH_TAB) ||
                       (i_char == wnt_pkg::CH_LF) || (i_char == wnt_pkg::CH_CR);
    assign held_kind = r_held_num ? wnt_pkg::KIND_NUMBER : wnt_pkg::KIND_IDENT;

    always_comb begin
        cont = 1'b0;
        if (r_held_valid && !i_eoi && (r_token_length < limit)) begin
            if (r_held_num) begin
                cont = wnt_pkg::is_digit(i_char) ||
                       ((i_char == wnt_pkg::CH_DOT) && !r_dot_seen);
            end else begin
                cont = is_alnum;
            end
        end
    end

    assign flush = r_held_valid && !cont;
    // A flush clears the held token first, so the current character is classified as from idle, not as comment text.
    assign in_comment = !flush && (r_mode == wnt_pkg::MODE_COMMENT);

    // Next state
    always_comb begin
        n_mode         = r_mode;
        n_held_char    = r_held_char;
        n_held_valid   = r_held_valid;
        n_held_num     = r_held_num;
        n_token_length = r_token_length;
        n_dot_seen     = r_dot_seen;
        if (i_en) begin
            if (cont) begin
                n_held_char    = i_char;
                n_token_length = r_token_length + 8'd1;
                if (i_char == wnt_pkg::CH_DOT) begin
                    n_dot_seen = 1'b1;
                end
            end else begin
                if (flush) begin
                    n_mode         = wnt_pkg::MODE_IDLE;
                    n_held_valid   = 1'b0;
                    n_held_num     = 1'b0;
                    n_token_length = 8'd0;
                    n_dot_seen     = 1'b0;
                end
                if (i_eoi) begin
                    n_mode         = wnt_pkg::MODE_IDLE;
                    n_held_valid   = 1'b0;
                    n_held_num     = 1'b0;
                    n_token_length = 8'd0;
                    n_dot_seen     = 1'b0;
                end else if (in_comment && i_skip_mode) begin
                    if (i_char == wnt_pkg::CH_LF) begin
                        n_mode = wnt_pkg::MODE_IDLE;
                    end
                end else begin
                    n_mode = wnt_pkg::MODE_IDLE;
                    if (i_skip_mode && is_blank) begin
                        n_mode = wnt_pkg::MODE_IDLE;
                    end else if (i_skip_mode && (i_char == wnt_pkg::CH_SEMI)) begin
                        n_mode = wnt_pkg::MODE_COMMENT;
                    end else if (is_alnum) begin
                        n_mode         = wnt_pkg::is_digit(i_char) ? wnt_pkg::MODE_NUMBER
                                                                   : wnt_pkg::MODE_IDENT;
                        n_held_char    = i_char;
                        n_held_valid   = 1'b1;
                        n_held_num     = wnt_pkg::is_digit(i_char);
                        n_token_length = 8'd1;
                        n_dot_seen     = 1'b0;
                    end
                end
            end
        end
    end

    // Outputs
    always_comb begin
        wnt_pkg::t_result sec;
        logic             sec_valid;
        sec       = '0;
        sec_valid = 1'b0;
        if (i_eoi) begin
            sec       = '{kind: wnt_pkg::KIND_END, ch: 8'd0, tend: 1'b1, last: 1'b1};
            sec_valid = 1'b1;
        end else if (!(in_comment && i_skip_mode) &&
                     !(i_skip_mode && is_blank) &&
                     !(i_skip_mode && (i_char == wnt_pkg::CH_SEMI)) && !is_alnum) begin
            sec       = '{kind: wnt_pkg::KIND_SYMBOL, ch: i_char, tend: 1'b1, last: 1'b1};
            sec_valid = 1'b1;
        end

        o_step = '0;
        if (cont) begin
            o_step.n    = 2'd1;
            o_step.res0 = '{kind: held_kind, ch: r_held_char, tend: 1'b0, last: 1'b1};
        end else if (flush) begin
            o_step.n    = sec_valid ? 2'd2 : 2'd1;
            o_step.res0 = '{kind: held_kind, ch: r_held_char, tend: 1'b1, last: !sec_valid};
            o_step.res1 = sec;
        end else begin
            o_step.n    = sec_valid ? 2'd1 : 2'd0;
            o_step.res0 = sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= wnt_pkg::MODE_IDLE;
            r_held_valid   <= 1'b0;
            r_held_num     <= 1'b0;
            r_token_length <= 8'd0;
            r_dot_seen     <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_held_valid   <= n_held_valid;
            r_held_num     <= n_held_num;
            r_token_length <= n_token_length;
            r_dot_seen     <= n_dot_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_char <= n_held_char;
    end

`ifndef SYNTH
    a_held_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid == ((r_mode == wnt_pkg::MODE_IDENT) || (r_mode == wnt_pkg::MODE_NUMBER)))
        else $error("held character flag disagrees with scan mode");
    a_dot_only_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_seen |-> (r_mode == wnt_pkg::MODE_NUMBER))
        else $error("dot flag set outside a number");
    a_eoi_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_eoi) |=> (r_mode == wnt_pkg::MODE_IDLE) && !r_held_valid)
        else $error("end of input did not return scanner to idle");
`endif

endmodule

>>> rtl/core/wnt_outq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
module wnt_outq #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wnt_pkg::t_step    i_step,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output wnt_pkg::t_result  o_result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    wnt_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wr_ptr1;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr1  = ptr_inc(r_wr_ptr);
    assign pop      = (r_count != '0) && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_step.n == 2'd1) begin
            n_wr_ptr = wr_ptr1;
        end else if (i_step.n == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_step.n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.res0;
        end
        if (i_step.n == 2'd2) begin
            r_mem[wr_ptr1] <= i_step.res1;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overfilled");
    a_write_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.n != 2'd0) |-> (32'(r_count) + 32'(i_step.n) - 32'(pop) <= DEPTH))
        else $error("result write exceeds free space");
    a_last_marks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.n == 2'd2) |-> (!i_step.res0.last && i_step.res1.last))
        else $error("run end flag misplaced in a two-result write");
`endif

endmodule

>>> rtl/core/word_number_tokenizer.sv
// Top level of the word/number tokenizer: config, input register, scanner, result queue.
// Path: a request is captured in the input register, then scanned once the result queue
//   has room; its results are written to the queue, which offers them on o_valid in order.
// Flow: one request per cycle while the result queue has room for two results; otherwise
//   the request waits in the input register until the queue drains enough room.
// Reset (synchronous, active low) clears scanner state and queue and restores
//   skip_mode to 1 and word_limit to 64; held character data is not cleared.
module word_number_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_input,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_char_out,
    output logic       o_token_end,
    output logic       o_last_of_run,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_skip_mode;
    logic [7:0] r_word_limit;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;

    logic             consume;
    logic             q_room;
    wnt_pkg::t_step   step;
    wnt_pkg::t_step   step_gated;
    wnt_pkg::t_result q_result;

    // Configuration registers: write straight from the port, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_mode  <= wnt_pkg::SKIP_MODE_RESET;
            r_word_limit <= wnt_pkg::WORD_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wnt_pkg::CFG_SKIP_MODE:  r_skip_mode  <= i_cfg_data[0];
                wnt_pkg::CFG_WORD_LIMIT: r_word_limit <= i_cfg_data;
                default:                 r_word_limit <= r_word_limit;
            endcase
        end
    end

    // Scan the held request only when the queue can absorb two results.
    assign consume = r_in_valid && q_room;
    assign o_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Capture request payload; hold it while the queue is short of room.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_in;
            r_in_eoi  <= i_end_of_input;
        end
    end

    wnt_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (consume),
        .i_char       (r_in_char),
        .i_eoi        (r_in_eoi),
        .i_skip_mode  (r_skip_mode),
        .i_word_limit (r_word_limit),
        .o_step       (step)
    );

    // Drop the scanner's results on cycles where nothing is scanned.
    always_comb begin
        step_gated = step;
        if (!consume) begin
            step_gated.n = 2'd0;
        end
    end

    wnt_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_gated),
        .o_room   (q_room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (q_result)
    );

    assign o_token_kind  = q_result.kind;
    assign o_char_out    = q_result.ch;
    assign o_token_end   = q_result.tend;
    assign o_last_of_run = q_result.last;

endmodule
